>>> rtl/spmf_pkg.sv
// Package: beat types and status codes for the strict-priority multilevel queue.
`default_nettype none

package spmf_pkg;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_BAD_LEVEL = 3'd1,
    ST_FULL      = 3'd2,
    ST_SERVED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ENQUEUE = 1'b0,
    MODE_SERVE   = 1'b1
  } mode_t;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned ENTRY_W = 2 * ID_W;

  typedef struct packed {
    mode_t               mode;
    logic [LEVEL_W-1:0]  level;
    logic [ID_W-1:0]     appointment_id;
    logic [ID_W-1:0]     patient_id;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [LEVEL_W-1:0]  served_level;
    logic [ID_W-1:0]     served_appointment_id;
    logic [ID_W-1:0]     served_patient_id;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/spmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module spmf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/strict_priority_multi_fifo.sv
// Top level: strict-priority multilevel queue, NUM_LEVELS FIFOs in one entry RAM.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+------------------------------------------
//   command  | start, busy, cmd       | beat taken when start && !busy
//   result   | done, result           | one-cycle strobe, receiver cannot stall
//
// Every command beat gives exactly one result beat in the cycle after it is taken:
// the entry RAM has a registered read, and that read sets when the result appears.
// A new command is taken every cycle; busy is never raised, since each beat
// touches one level's pointers and one RAM word, and a serve's read data is
// captured before the next beat can write the same word.
// Reset (rst, synchronous) empties every level; the RAM itself is not cleared,
// as a word is only read while its level's fill count covers it.
`default_nettype none

module strict_priority_multi_fifo
  import spmf_pkg::*;
#(
  parameter int unsigned NUM_LEVELS  = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         done,
  output result_t      result
);

  localparam int unsigned LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Per-level pointers and occupancy counts.
  logic [PW-1:0] head [NUM_LEVELS];
  logic [PW-1:0] tail [NUM_LEVELS];
  logic [FW-1:0] fill [NUM_LEVELS];

  logic          accept;
  logic          level_ok;
  logic [LW-1:0] enq_q;
  logic          enq_full;
  logic          do_enq;

  // Highest non-empty level for a serve.
  logic [LW-1:0] srv_q;
  logic          any_waiting;
  logic          do_srv;

  // RAM ports.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  // Result stage.
  logic               out_valid;
  status_t            out_status;
  logic [LEVEL_W-1:0] out_level;
  logic               out_served;
  status_t            status_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Enqueue decode: level 1..NUM_LEVELS maps to queue index level-1.
  assign level_ok = (cmd.level != '0) && (32'(cmd.level) <= NUM_LEVELS);
  assign enq_q    = LW'(32'(cmd.level) - 32'd1);
  assign enq_full = level_ok && (fill[enq_q] == FW'(QUEUE_DEPTH));
  assign do_enq   = accept && (cmd.mode == MODE_ENQUEUE) && level_ok && !enq_full;

  // Fixed priority encoder: later (higher) levels override lower ones.
  always_comb begin
    srv_q       = '0;
    any_waiting = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill[i] != '0) begin
        srv_q       = LW'(i);
        any_waiting = 1'b1;
      end
    end
  end

  assign do_srv = accept && (cmd.mode == MODE_SERVE) && any_waiting;

  // Each level owns a contiguous block of QUEUE_DEPTH words.
  assign ram_we    = do_enq;
  assign ram_waddr = AW'(32'(enq_q) * QUEUE_DEPTH + 32'(tail[enq_q]));
  assign ram_raddr = AW'(32'(srv_q) * QUEUE_DEPTH + 32'(head[srv_q]));

  spmf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cmd.appointment_id, cmd.patient_id}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pointer and count update; enqueue and serve never happen in the same beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else if (do_enq) begin
      tail[enq_q] <= (tail[enq_q] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail[enq_q] + PW'(1);
      fill[enq_q] <= fill[enq_q] + FW'(1);
    end else if (do_srv) begin
      head[srv_q] <= (head[srv_q] == PW'(QUEUE_DEPTH - 1)) ? '0 : head[srv_q] + PW'(1);
      fill[srv_q] <= fill[srv_q] - FW'(1);
    end
  end

  always_comb begin
    if (cmd.mode == MODE_SERVE) begin
      status_next = any_waiting ? ST_SERVED : ST_EMPTY;
    end else if (!level_ok) begin
      status_next = ST_BAD_LEVEL;
    end else if (enq_full) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_ADDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= status_next;
    out_served <= do_srv;
    out_level  <= LEVEL_W'(32'(srv_q) + 32'd1);
  end

  // Served data arrives from the RAM in the result cycle; zero otherwise.
  assign done                         = out_valid;
  assign result.status                = out_status;
  assign result.served_level          = out_served ? out_level : '0;
  assign result.served_appointment_id = out_served ? ram_rdata[ENTRY_W-1:ID_W] : '0;
  assign result.served_patient_id     = out_served ? ram_rdata[ID_W-1:0] : '0;

endmodule

`default_nettype wire
